// ===== hw/rtl/lqe_pkg.sv =====
// Package for the linear queue engine: opcode, status and state codes,
// and the command/status structs shared by controller and datapath. No dependencies.
package lqe_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } st_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // latch request, read front slot
    logic ins;      // write item at rear
    logic del;      // advance front
    logic step;     // advance dump pointer, read next slot
    logic emit;     // load result registers
    st_e  status;
    logic use_mem;  // result value comes from read data
    logic last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic dump_last;
  } stat_t;

endpackage

// ===== hw/rtl/lqe_ctrl.sv =====
// Controller of the linear queue engine: request sequencing state machine.
// Depends on lqe_pkg.
module lqe_ctrl import lqe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = ST_OK;
    busy_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        busy_o  = 1'b1;
        state_d = S_IDLE;
        case (stat_i.op)
          OP_INSERT: begin
            cmd_o.emit = 1'b1;
            cmd_o.last = 1'b1;
            if (stat_i.full) begin
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.ins = 1'b1;
            end
          end
          OP_DELETE: begin
            cmd_o.emit = 1'b1;
            cmd_o.last = 1'b1;
            if (stat_i.empty) begin
              cmd_o.status = ST_EMPTY;
            end else begin
              cmd_o.del     = 1'b1;
              cmd_o.use_mem = 1'b1;
            end
          end
          OP_DUMP: begin
            cmd_o.emit = 1'b1;
            if (stat_i.empty) begin
              cmd_o.status = ST_EMPTY;
              cmd_o.last   = 1'b1;
            end else begin
              cmd_o.use_mem = 1'b1;
              cmd_o.last    = stat_i.dump_last;
              if (!stat_i.dump_last) begin
                cmd_o.step = 1'b1;
                state_d    = S_EXEC;
              end
            end
          end
          default: begin
            // unused opcode: dropped without a result
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/lqe_dpath.sv =====
// Datapath of the linear queue engine: slot memory, front/rear pointers,
// dump pointer and result registers. Depends on lqe_pkg.
module lqe_dpath import lqe_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] item_value_i,
  output stat_t              stat_o,
  output logic               result_valid_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] value_o,
  output logic               is_last_o
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [31:0]   slots [QUEUE_DEPTH];
  logic [31:0]   rdata_q;
  logic [31:0]   item_q;
  op_e           op_q;
  logic [CW-1:0] head_q, head_d, tail_q, tail_d, ptr_q, ptr_d;
  logic [CW-1:0] head_inc, ptr_inc;
  logic [IW-1:0] rd_addr;
  logic          valid_q;
  logic [1:0]    status_q;
  logic [31:0]   value_q;
  logic          last_q;

  assign head_inc = head_q + CW'(1);
  assign ptr_inc  = ptr_q + CW'(1);
  assign rd_addr  = cmd_i.accept ? head_q[IW-1:0] : ptr_inc[IW-1:0];

  assign stat_o.op        = op_q;
  assign stat_o.full      = (tail_q == CW'(QUEUE_DEPTH));
  assign stat_o.empty     = (head_q >= tail_q);
  assign stat_o.dump_last = (ptr_inc == tail_q);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    ptr_d  = ptr_q;
    if (cmd_i.accept) begin
      ptr_d = head_q;
    end
    if (cmd_i.step) begin
      ptr_d = ptr_inc;
    end
    if (cmd_i.ins) begin
      tail_d = tail_q + CW'(1);
    end
    if (cmd_i.del) begin
      // queue drained: both pointers back to the start
      if (head_inc >= tail_q) begin
        head_d = '0;
        tail_d = '0;
      end else begin
        head_d = head_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      ptr_q   <= '0;
      op_q    <= OP_INSERT;
      valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      ptr_q   <= ptr_d;
      valid_q <= cmd_i.emit;
      if (cmd_i.accept) begin
        op_q <= op_e'(opcode_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= item_value_i;
    end
    if (cmd_i.emit) begin
      status_q <= cmd_i.status;
      value_q  <= cmd_i.use_mem ? rdata_q : 32'd0;
      last_q   <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins) begin
      slots[tail_q[IW-1:0]] <= item_q;
    end
    rdata_q <= slots[rd_addr];
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign value_o        = value_q;
  assign is_last_o      = last_q;

endmodule

// ===== hw/rtl/linear_queue_engine_unit.sv =====
// Top level of the linear queue engine: controller plus datapath.
// Depends on lqe_pkg, lqe_ctrl, lqe_dpath.
//
// A request is taken when start is high and busy is low. Insert and delete
// each give one result, loaded into the result registers from the execute state,
// and free the block for a new request when that state ends; a new request is
// not taken before the last one is through. A dump gives one result per stored
// entry, one per cycle, and holds busy until the last; the pace is set by the
// single read port of the slot memory, whose registered read feeds each result.
// Results appear on result_valid_o for one cycle each and cannot be held off, so
// the receiver must take every strobe. Opcode 3 is accepted and gives no result.
module linear_queue_engine_unit import lqe_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] item_value_i,
  output logic               result_valid_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] value_o,
  output logic               is_last_o
);

  cmd_t  cmd;
  stat_t stat;

  lqe_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  lqe_dpath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .opcode_i      (opcode_i),
    .item_value_i  (item_value_i),
    .stat_o        (stat),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .value_o       (value_o),
    .is_last_o     (is_last_o)
  );

endmodule

// ===== tb/sv/tb_linear_queue_engine_unit.sv =====
// Self-checking testbench for linear_queue_engine_unit: insert, delete and dump requests
// run against an in-bench queue model, with random gaps. Depends on lqe_pkg and the DUT.
`timescale 1ns / 100ps

module tb_linear_queue_engine_unit;
  import lqe_pkg::*;

  localparam int DEPTH      = 8;
  localparam int N_RANDOM   = 85;
  localparam int CYCLE_CAP  = 200000;
  localparam int DRAIN_WAIT = 24;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] val;
  } request_t;

  typedef struct {
    st_e         st;
    logic [31:0] val;
    logic        last;
  } queue_out_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         opcode_i;
  logic signed [31:0] item_value_i;
  logic               result_valid_o;
  logic [1:0]         status_o;
  logic signed [31:0] value_o;
  logic               is_last_o;

  request_t   req_backlog[$];
  queue_out_t queue_outputs[$];

  // queue model
  logic [31:0] mdl_slot [DEPTH];
  int unsigned mdl_head;
  int unsigned mdl_tail;

  int unsigned n_errors;
  int unsigned gap_left;
  int unsigned cycles;

  linear_queue_engine_unit #(.QUEUE_DEPTH(DEPTH)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .item_value_i  (item_value_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .value_o       (value_o),
    .is_last_o     (is_last_o)
  );

  task automatic post_result(input st_e st, input logic [31:0] val, input logic last);
    queue_out_t r;
    r.st   = st;
    r.val  = val;
    r.last = last;
    queue_outputs.push_back(r);
  endtask

  task automatic queue_apply(input logic [1:0] op, input logic [31:0] val);
    int unsigned i;
    case (op)
      OP_INSERT: begin
        if (mdl_tail >= DEPTH) begin
          post_result(ST_FULL, '0, 1'b1);
        end else begin
          mdl_slot[mdl_tail] = val;
          mdl_tail++;
          post_result(ST_OK, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        if (mdl_head >= mdl_tail) begin
          post_result(ST_EMPTY, '0, 1'b1);
        end else begin
          post_result(ST_OK, mdl_slot[mdl_head], 1'b1);
          mdl_head++;
          // last entry gone: both pointers back to reset
          if (mdl_head >= mdl_tail) begin
            mdl_head = 0;
            mdl_tail = 0;
          end
        end
      end
      OP_DUMP: begin
        if (mdl_head >= mdl_tail) begin
          post_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (i = mdl_head; i < mdl_tail; i++) begin
            post_result(ST_OK, mdl_slot[i], (i + 1 == mdl_tail));
          end
        end
      end
      default: ;  // unused opcode, no result
    endcase
  endtask

  task automatic add_req(input logic [1:0] op, input logic [31:0] val);
    request_t r;
    r.op  = op;
    r.val = val;
    req_backlog.push_back(r);
  endtask

  function automatic logic [31:0] rand_value();
    int unsigned r;
    r = $urandom_range(0, 15);
    case (r)
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 9);
    return $urandom_range(15, 40);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start        <= 1'b0;
      opcode_i     <= '0;
      item_value_i <= '0;
      gap_left     =  0;
      mdl_head     =  0;
      mdl_tail     =  0;
    end else begin
      logic    take;
      request_t r;
      take = start && !busy;
      if (take) begin
        queue_apply(opcode_i, item_value_i);
        gap_left = pick_gap();
      end
      if (start && !take) begin
        // request held until the block takes it
      end else if (gap_left > 0) begin
        gap_left--;
        start        <= 1'b0;
        opcode_i     <= 2'($urandom_range(0, 3));
        item_value_i <= $urandom;
      end else if (req_backlog.size() > 0) begin
        r = req_backlog.pop_front();
        start        <= 1'b1;
        opcode_i     <= r.op;
        item_value_i <= r.val;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    queue_out_t e;
    if (rst_ni && result_valid_o) begin
      if (queue_outputs.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%h last=%b",
                 $realtime, status_o, value_o, is_last_o);
        n_errors++;
      end else begin
        e = queue_outputs.pop_front();
        if (status_o !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $realtime, e.st, status_o);
          n_errors++;
        end
        if (value_o !== e.val) begin
          $display("%0t: value expected %h actual %h", $realtime, e.val, value_o);
          n_errors++;
        end
        if (is_last_o !== e.last) begin
          $display("%0t: is_last expected %b actual %b", $realtime, e.last, is_last_o);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned n_items;
    int unsigned seg;
    int unsigned len;
    int unsigned k;
    n_errors = 0;
    cycles   = 0;
    rst_ni   = 1'b0;

    // directed: empty cases, fill to full, full insert with the front advanced,
    // partial dump, drain to reset, unused opcode
    add_req(OP_DUMP, 32'h1111_1111);
    add_req(OP_DELETE, 32'hffff_ffff);
    add_req(2'd3, 32'h7fff_ffff);
    add_req(OP_INSERT, 32'h8000_0000);
    add_req(OP_INSERT, 32'h7fff_ffff);
    add_req(OP_INSERT, 32'h0000_0000);
    add_req(OP_INSERT, 32'hffff_ffff);
    add_req(OP_INSERT, 32'h5555_5555);
    add_req(OP_INSERT, 32'haaaa_aaaa);
    add_req(OP_INSERT, 32'h0000_0001);
    add_req(OP_INSERT, 32'h8000_0001);
    add_req(OP_DUMP, 32'h0);
    add_req(OP_INSERT, 32'h1234_5678);
    add_req(OP_DELETE, 32'h0);
    add_req(OP_INSERT, 32'h1234_5678);
    add_req(OP_DUMP, 32'hffff_ffff);
    for (k = 0; k < 7; k++) add_req(OP_DELETE, $urandom);
    add_req(OP_DELETE, 32'h0);
    add_req(2'd3, 32'h8000_0000);

    // random segments: fill runs, drain runs, mixed, and noise
    n_items = 0;
    while (n_items < N_RANDOM) begin
      seg = $urandom_range(0, 9);
      len = $urandom_range(1, DEPTH + 1);
      for (k = 0; k < len; k++) begin
        if (seg < 4) begin
          add_req(($urandom_range(0, 5) == 0) ? OP_DUMP : OP_INSERT, rand_value());
          n_items++;
        end else if (seg < 7) begin
          add_req(($urandom_range(0, 5) == 0) ? OP_DUMP : OP_DELETE, rand_value());
          n_items++;
        end else if (seg < 9) begin
          add_req(2'($urandom_range(0, 2)), rand_value());
          n_items++;
        end else begin
          add_req(2'd3, rand_value());
        end
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (req_backlog.size() > 0 || start) @(posedge clk_i);
    while (queue_outputs.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
